### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Bodies vanish in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PFF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define PFF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define PFF_ASSERT(lbl, clk, rst, prop, msg)

`define PFF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/core/pff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pff_pkg;

  localparam int PORTAL_DEPTH_DEF = 32;
  localparam int MAX_OUT          = 32;
  localparam int COORD_W          = 24;
  localparam int LIMIT_W          = 16;
  localparam int ACC_W            = 52;
  localparam int NOUT_W           = 6;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd17;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_PORTAL = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pt_t;

  typedef struct packed {
    pt_t lp;
    pt_t rp;
  } portal_t;

  typedef struct packed {
    logic [1:0] kind;
    pt_t        lp;
    pt_t        rp;
  } cmd_t;

  typedef enum logic {
    GEO_TRI,
    GEO_SAME
  } geo_op_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] value;
    logic                    less;
  } geo_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BEGIN,
    S_FETCH,
    S_LOAD,
    S_LAUNCH,
    S_WAIT,
    S_EMIT,
    S_CHECK,
    S_END
  } state_t;

  typedef enum logic [2:0] {
    T_R_TRI,
    T_R_SAME,
    T_R_CROSS,
    T_L_TRI,
    T_L_SAME,
    T_L_CROSS
  } test_t;

endpackage

`default_nettype wire

### rtl/core/pff_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pff_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic signed [23:0]       left_x;
  logic signed [23:0]       left_y;
  logic signed [23:0]       left_z;
  logic signed [23:0]       right_x;
  logic signed [23:0]       right_y;
  logic signed [23:0]       right_z;

  modport source (output valid, kind, left_x, left_y, left_z, right_x, right_y, right_z,
                  input ready);
  modport sink   (input valid, kind, left_x, left_y, left_z, right_x, right_y, right_z,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/pff_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pff_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic signed [23:0] point_z;
  logic               last;
  logic               overflow;

  modport source (output valid, point_x, point_y, point_z, last, overflow, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last, overflow, output ready);
endinterface

`default_nettype wire

### rtl/core/pff_front.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pff_front
  import pff_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  pff_in_if.sink    in_ch,
  output cmd_t      q_item,
  output logic      q_valid,
  input  wire logic q_pop
);

  cmd_t       fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_cnt;
  logic       push;
  cmd_t       cmd_in;

  assign in_ch.ready = (q_cnt != 2'd2);
  // drop unused kinds at the door
  assign push    = in_ch.valid && in_ch.ready && (in_ch.kind != KIND_UNUSED);
  assign q_valid = (q_cnt != 2'd0);
  assign q_item  = fifo[rd_ptr];

  always_comb begin
    cmd_in.kind = in_ch.kind;
    cmd_in.lp   = '{x: in_ch.left_x, y: in_ch.left_y, z: in_ch.left_z};
    cmd_in.rp   = '{x: in_ch.right_x, y: in_ch.right_y, z: in_ch.right_z};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      q_cnt <= q_cnt + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end

  `PFF_ASSERT(a_qcnt_range, clk, rst, q_cnt <= 2'd2, "queue count out of range")
  `PFF_ASSERT_IMP(a_pop_nonempty, clk, rst, q_pop, q_valid, "pop from empty queue")

endmodule

`default_nettype wire

### rtl/core/pff_geom.sv
`timescale 1ns / 1ps
`default_nettype none

module pff_geom
  import pff_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  geo_op_t                  op,
  input  pt_t                      a,
  input  pt_t                      b,
  input  pt_t                      c,
  input  wire logic [LIMIT_W-1:0]  limit,
  output geo_res_t                 res
);

  geo_op_t                   op_q;
  pt_t                       a_q;
  pt_t                       b_q;
  pt_t                       c_q;
  logic                      busy;
  logic                      done;
  logic [1:0]                step;
  logic signed [49:0]        prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [24:0]        f;
  logic signed [24:0]        g;
  logic [1:0]                nprod;
  logic signed [ACC_W-1:0]   prod_ext;

  function automatic logic signed [24:0] sdiff(input logic signed [23:0] p,
                                               input logic signed [23:0] q);
    return $signed({p[23], p}) - $signed({q[23], q});
  endfunction

  assign nprod    = (op_q == GEO_SAME) ? 2'd3 : 2'd2;
  assign prod_ext = ACC_W'(prod);

  always_comb begin
    f = '0;
    g = '0;
    if (op_q == GEO_TRI) begin
      if (step == 2'd0) begin
        f = sdiff(b_q.x, a_q.x);
        g = sdiff(c_q.z, a_q.z);
      end else begin
        f = sdiff(b_q.z, a_q.z);
        g = sdiff(c_q.x, a_q.x);
      end
    end else begin
      case (step)
        2'd0:    f = sdiff(a_q.x, b_q.x);
        2'd1:    f = sdiff(a_q.y, b_q.y);
        default: f = sdiff(a_q.z, b_q.z);
      endcase
      g = f;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_q <= op;
      a_q  <= a;
      b_q  <= b;
      c_q  <= c;
    end
    if (busy && step < nprod) begin
      prod <= f * g;
    end
    if (busy && step != 2'd0) begin
      if (step == 2'd1) begin
        acc <= prod_ext;
      end else if (op_q == GEO_TRI) begin
        acc <= acc - prod_ext;
      end else begin
        acc <= acc + prod_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == nprod) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done  = done;
  assign res.value = acc;
  assign res.less  = acc < $signed({{(ACC_W-LIMIT_W){1'b0}}, limit});

endmodule

`default_nettype wire

### rtl/core/pff_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pff_back
  import pff_pkg::*;
#(
  parameter int PORTAL_DEPTH = PORTAL_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  cmd_t                    q_item,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata,
  pff_out_if.source               out_ch
);

  localparam int AW = $clog2(PORTAL_DEPTH);
  localparam int CW = $clog2(PORTAL_DEPTH + 1);
  localparam int IW = $clog2(PORTAL_DEPTH + 3);

  portal_t              mem [PORTAL_DEPTH];
  portal_t              rd_q;
  logic [LIMIT_W-1:0]   limit;
  logic [CW-1:0]        count;
  logic                 dropped;
  pt_t                  start_pt;
  pt_t                  end_pt;
  pt_t                  apex;
  pt_t                  left;
  pt_t                  right;
  pt_t                  l_pt;
  pt_t                  r_pt;
  logic [IW-1:0]        ai;
  logic [IW-1:0]        li;
  logic [IW-1:0]        ri;
  logic [IW-1:0]        i;
  logic [IW-1:0]        rd_idx;
  logic [NOUT_W-1:0]    n;
  logic                 corner_right;
  state_t               state;
  state_t               state_next;
  test_t                test;
  test_t                test_next;

  logic                 o_valid;
  pt_t                  o_pt;
  logic                 o_last;
  logic                 o_ovf;
  logic                 out_free;

  logic                 geo_start;
  geo_op_t              geo_op;
  pt_t                  geo_b;
  pt_t                  geo_c;
  geo_res_t             res;
  logic                 le_zero;

  logic                 emit;
  pt_t                  emit_pt;
  logic                 emit_last;
  logic                 acc_r;
  logic                 acc_l;
  logic                 adv;
  logic                 restart_l;
  logic                 restart_r;
  logic                 rebase;
  pt_t                  corner;
  logic [IW-1:0]        corner_idx;
  logic                 portal_wr;

  pff_geom u_geom (
    .clk   (clk),
    .rst   (rst),
    .start (geo_start),
    .op    (geo_op),
    .a     (apex),
    .b     (geo_b),
    .c     (geo_c),
    .limit (limit),
    .res   (res)
  );

  assign out_free   = !o_valid || out_ch.ready;
  assign le_zero    = res.value[ACC_W-1] || (res.value == '0);
  assign corner     = corner_right ? right : left;
  assign corner_idx = corner_right ? ri : li;
  assign rd_idx     = i - IW'(1);
  assign portal_wr  = q_pop && (q_item.kind == KIND_PORTAL) && (count < CW'(PORTAL_DEPTH));

  // operand selection for the shared geometry unit
  always_comb begin
    geo_op = GEO_TRI;
    geo_b  = right;
    geo_c  = r_pt;
    case (test)
      T_R_TRI:   begin geo_op = GEO_TRI;  geo_b = right; geo_c = r_pt; end
      T_R_SAME:  begin geo_op = GEO_SAME; geo_b = right; geo_c = r_pt; end
      T_R_CROSS: begin geo_op = GEO_TRI;  geo_b = left;  geo_c = r_pt; end
      T_L_TRI:   begin geo_op = GEO_TRI;  geo_b = left;  geo_c = l_pt; end
      T_L_SAME:  begin geo_op = GEO_SAME; geo_b = left;  geo_c = l_pt; end
      T_L_CROSS: begin geo_op = GEO_TRI;  geo_b = right; geo_c = l_pt; end
      default:   begin geo_op = GEO_TRI;  geo_b = right; geo_c = r_pt; end
    endcase
  end

  always_comb begin
    state_next = state;
    test_next  = test;
    q_pop      = 1'b0;
    geo_start  = 1'b0;
    emit       = 1'b0;
    emit_pt    = end_pt;
    emit_last  = 1'b0;
    acc_r      = 1'b0;
    acc_l      = 1'b0;
    adv        = 1'b0;
    restart_l  = 1'b0;
    restart_r  = 1'b0;
    rebase     = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.kind == KIND_END) begin
            state_next = (count == '0) ? S_END : S_BEGIN;
          end
        end
      end
      S_BEGIN: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_pt    = start_pt;
          state_next = S_FETCH;
        end
      end
      S_FETCH: state_next = S_LOAD;
      S_LOAD: begin
        test_next  = T_R_TRI;
        state_next = S_LAUNCH;
      end
      S_LAUNCH: begin
        geo_start  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (res.done) begin
          state_next = S_LAUNCH;
          case (test)
            T_R_TRI: begin
              if (!le_zero) begin
                test_next = T_L_TRI;
              end else if (ri == ai) begin
                acc_r     = 1'b1;
                test_next = T_L_TRI;
              end else begin
                test_next = T_R_SAME;
              end
            end
            T_R_SAME: begin
              if (res.less) begin
                acc_r     = 1'b1;
                test_next = T_L_TRI;
              end else begin
                test_next = T_R_CROSS;
              end
            end
            T_R_CROSS: begin
              if (!le_zero) begin
                acc_r     = 1'b1;
                test_next = T_L_TRI;
              end else begin
                restart_l  = 1'b1;
                state_next = S_EMIT;
              end
            end
            T_L_TRI: begin
              if (!le_zero) begin
                adv        = 1'b1;
                state_next = S_CHECK;
              end else if (li == ai) begin
                acc_l      = 1'b1;
                adv        = 1'b1;
                state_next = S_CHECK;
              end else begin
                test_next = T_L_SAME;
              end
            end
            T_L_SAME: begin
              if (res.less) begin
                acc_l      = 1'b1;
                adv        = 1'b1;
                state_next = S_CHECK;
              end else begin
                test_next = T_L_CROSS;
              end
            end
            T_L_CROSS: begin
              if (res.value[ACC_W-1]) begin
                acc_l      = 1'b1;
                adv        = 1'b1;
                state_next = S_CHECK;
              end else begin
                restart_r  = 1'b1;
                state_next = S_EMIT;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_EMIT: begin
        // corners that would leave no slot for the end are skipped
        if (n >= NOUT_W'(MAX_OUT - 1)) begin
          rebase     = 1'b1;
          state_next = S_CHECK;
        end else if (out_free) begin
          emit       = 1'b1;
          emit_pt    = corner;
          rebase     = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = (i > IW'(count) + IW'(1)) ? S_END : S_FETCH;
      end
      S_END: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_pt    = end_pt;
          emit_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (portal_wr) begin
      mem[count[AW-1:0]] <= '{lp: q_item.lp, rp: q_item.rp};
    end
    rd_q <= mem[rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      test    <= T_R_TRI;
      limit   <= LIMIT_RESET;
      count   <= '0;
      dropped <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      test  <= test_next;
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      if (q_pop) begin
        if (q_item.kind == KIND_START) begin
          count   <= '0;
          dropped <= 1'b0;
        end else if (q_item.kind == KIND_PORTAL) begin
          if (portal_wr) begin
            count <= count + CW'(1);
          end else begin
            dropped <= 1'b1;
          end
        end
      end
      if (emit && emit_last) begin
        count   <= '0;
        dropped <= 1'b0;
      end
      if (emit) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pt <= '0;
    end else if (q_pop && q_item.kind == KIND_START) begin
      start_pt <= q_item.lp;
    end
    if (q_pop && q_item.kind == KIND_END) begin
      end_pt <= q_item.lp;
      apex   <= start_pt;
      left   <= start_pt;
      right  <= start_pt;
      ai     <= '0;
      li     <= '0;
      ri     <= '0;
      i      <= IW'(1);
      n      <= '0;
    end
    if (state == S_LOAD) begin
      if (i > IW'(count)) begin
        l_pt <= end_pt;
        r_pt <= end_pt;
      end else begin
        l_pt <= rd_q.lp;
        r_pt <= rd_q.rp;
      end
    end
    if (acc_r) begin
      right <= r_pt;
      ri    <= i;
    end
    if (acc_l) begin
      left <= l_pt;
      li   <= i;
    end
    if (adv) begin
      i <= i + IW'(1);
    end
    if (restart_l) begin
      corner_right <= 1'b0;
    end
    if (restart_r) begin
      corner_right <= 1'b1;
    end
    if (rebase) begin
      apex  <= corner;
      left  <= corner;
      right <= corner;
      ai    <= corner_idx;
      li    <= corner_idx;
      ri    <= corner_idx;
      i     <= corner_idx + IW'(1);
    end
    if (emit) begin
      n <= n + NOUT_W'(1);
    end
    if (emit) begin
      o_pt   <= emit_pt;
      o_last <= emit_last;
      o_ovf  <= dropped;
    end
  end

  assign out_ch.valid    = o_valid;
  assign out_ch.point_x  = o_pt.x;
  assign out_ch.point_y  = o_pt.y;
  assign out_ch.point_z  = o_pt.z;
  assign out_ch.last     = o_last;
  assign out_ch.overflow = o_ovf;

  `PFF_ASSERT(a_count_range, clk, rst, count <= CW'(PORTAL_DEPTH), "portal count beyond depth")
  `PFF_ASSERT_IMP(a_geo_done_wait, clk, rst, res.done, state == S_WAIT, "geometry result unclaimed")
  `PFF_ASSERT_IMP(a_emit_free, clk, rst, emit, out_free, "result register overwritten")

endmodule

`default_nettype wire

### rtl/core/portal_funnel_path_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Funnel path walker. Send a start item, then up to PORTAL_DEPTH portal items
// (left and right edge points, Q12.12), then an end item; the end item returns
// the start, each apex corner and the end as waypoints, the end flagged with
// last (only the end when no portals were sent). Portals beyond the store are
// dropped and reported by overflow on every waypoint of that path. Start and
// portal items pass through a two-entry command queue. The end item walks the
// corridor on one shared geometry unit with one 25x25 multiplier: each portal
// step runs a store fetch, a load and an index check around its tests (turn
// tests take 2 products, same-point tests 3), two to six tests a step, and
// each apex restart walks again from the new apex index. Waypoints leave
// through a registered output stage, so a stalled sink only holds the walk.
// same_point_limit (reset 17) is written through cfg_we/cfg_wdata, only while
// idle by rule for the user; the block itself does no such check.
module portal_funnel_path_top
  import pff_pkg::*;
#(
  parameter int PORTAL_DEPTH = PORTAL_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  pff_in_if.sink                  in_ch,
  pff_out_if.source               out_ch,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata
);

  cmd_t q_item;
  logic q_valid;
  logic q_pop;

  pff_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  pff_back #(
    .PORTAL_DEPTH (PORTAL_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

### dv/tb_chan_if.sv
`timescale 1ns / 1ps

// Both channel interfaces come from the RTL (pff_in_if, pff_out_if); this file
// holds the bench's own transfer records: the driver's command and the monitor's waypoint.
package tb_chan_pkg;
  import pff_pkg::*;

  typedef struct {
    logic [1:0]          kind;
    logic signed [23:0]  lx, ly, lz, rx, ry, rz;
  } path_cmd_t;

  typedef struct {
    logic signed [23:0] x, y, z;
    logic               last;
    logic               ovf;
  } waypoint_t;
endpackage

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import pff_pkg::*;
  import tb_chan_pkg::*;

  localparam int DEPTH = 32;
  localparam longint LIMIT_CYCLES = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  pff_in_if  in_ch();
  pff_out_if out_ch();

  portal_funnel_path_top DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [15:0] lim_q = 16'd17;
  longint st_x[DEPTH], st_y[DEPTH], st_z[DEPTH];
  longint sr_x[DEPTH], sr_y[DEPTH], sr_z[DEPTH];
  int     n_portals = 0;
  bit     dropped = 0;
  longint org_x = 0, org_y = 0, org_z = 0;

  path_cmd_t pending_cmds[$];
  waypoint_t expected_pts[$];
  int  mismatches = 0;
  bit  failed = 0;
  bit  calm = 0;
  bit  send_hold = 0;
  bit  hold_go = 0;
  bit  hold_rx = 0;
  longint cycles = 0;

  function automatic longint turn(longint ax, longint az, longint bx, longint bz,
                                  longint cx, longint cz);
    return (bx - ax) * (cz - az) - (bz - az) * (cx - ax);
  endfunction

  function automatic bit near(longint ax, longint ay, longint az,
                              longint bx, longint by, longint bz);
    longint dx, dy, dz;
    dx = ax - bx; dy = ay - by; dz = az - bz;
    return (dx * dx + dy * dy + dz * dz) < longint'(lim_q);
  endfunction

  function automatic void push_pt(ref int n, input longint x, y, z, input bit lst);
    waypoint_t w;
    if (n >= MAX_OUT) return;
    w.x = x[23:0]; w.y = y[23:0]; w.z = z[23:0]; w.last = lst; w.ovf = dropped;
    expected_pts = {expected_pts, w};
    n++;
  endfunction

  function automatic void corner(int i, bit side, longint ex, ey, ez,
                                 output longint x, y, z);
    if (i == 0) begin x = org_x; y = org_y; z = org_z; end
    else if (i > n_portals) begin x = ex; y = ey; z = ez; end
    else if (side) begin x = sr_x[i-1]; y = sr_y[i-1]; z = sr_z[i-1]; end
    else begin x = st_x[i-1]; y = st_y[i-1]; z = st_z[i-1]; end
  endfunction

  function automatic void walk_path(longint ex, ey, ez);
    int n, ai, li, ri, i;
    longint axx, ayy, azz, lxx, lyy, lzz, rxx, ryy, rzz;
    longint plx, ply, plz, prx, pry, prz;
    n = 0; ai = 0; li = 0; ri = 0;
    if (n_portals == 0) begin
      push_pt(n, ex, ey, ez, 1);
      return;
    end
    axx = org_x; ayy = org_y; azz = org_z;
    lxx = axx; lyy = ayy; lzz = azz; rxx = axx; ryy = ayy; rzz = azz;
    push_pt(n, axx, ayy, azz, 0);
    i = 1;
    while (i <= n_portals + 1) begin
      corner(i, 0, ex, ey, ez, plx, ply, plz);
      corner(i, 1, ex, ey, ez, prx, pry, prz);
      if (turn(axx, azz, rxx, rzz, prx, prz) <= 0) begin
        if (ri == ai || near(axx, ayy, azz, rxx, ryy, rzz) ||
            turn(axx, azz, lxx, lzz, prx, prz) > 0) begin
          rxx = prx; ryy = pry; rzz = prz; ri = i;
        end else begin
          if (n < MAX_OUT - 1) push_pt(n, lxx, lyy, lzz, 0);
          axx = lxx; ayy = lyy; azz = lzz; ai = li;
          lxx = axx; lyy = ayy; lzz = azz; li = ai;
          rxx = axx; ryy = ayy; rzz = azz; ri = ai;
          i = ai + 1;
          continue;
        end
      end
      if (turn(axx, azz, lxx, lzz, plx, plz) <= 0) begin
        if (li == ai || near(axx, ayy, azz, lxx, lyy, lzz) ||
            turn(axx, azz, rxx, rzz, plx, plz) < 0) begin
          lxx = plx; lyy = ply; lzz = plz; li = i;
        end else begin
          if (n < MAX_OUT - 1) push_pt(n, rxx, ryy, rzz, 0);
          axx = rxx; ayy = ryy; azz = rzz; ai = ri;
          lxx = axx; lyy = ayy; lzz = azz; li = ai;
          rxx = axx; ryy = ayy; rzz = azz; ri = ai;
          i = ai + 1;
          continue;
        end
      end
      i++;
    end
    push_pt(n, ex, ey, ez, 1);
  endfunction

  function automatic void predict_cmd(path_cmd_t c);
    case (c.kind)
      KIND_START: begin
        org_x = c.lx; org_y = c.ly; org_z = c.lz;
        n_portals = 0; dropped = 0;
      end
      KIND_PORTAL: begin
        if (n_portals < DEPTH) begin
          st_x[n_portals] = c.lx; st_y[n_portals] = c.ly; st_z[n_portals] = c.lz;
          sr_x[n_portals] = c.rx; sr_y[n_portals] = c.ry; sr_z[n_portals] = c.rz;
          n_portals++;
        end else dropped = 1;
      end
      KIND_END: begin
        walk_path(c.lx, c.ly, c.lz);
        n_portals = 0; dropped = 0;
      end
      default: ;
    endcase
  endfunction

  // driver
  initial begin
    in_ch.valid = 1'b0; in_ch.kind = '0;
    in_ch.left_x = '0; in_ch.left_y = '0; in_ch.left_z = '0;
    in_ch.right_x = '0; in_ch.right_y = '0; in_ch.right_z = '0;
    out_ch.ready = 1'b0;
  end

  int gap_tx = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_cmd(pending_cmds.pop_front());
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_tx > 0) begin
          gap_tx <= gap_tx - 1;
          in_ch.valid <= 1'b0;
        end else if (!send_hold && pending_cmds.size() > 0) begin
          path_cmd_t c;
          c = pending_cmds[0];
          in_ch.valid <= 1'b1; in_ch.kind <= c.kind;
          in_ch.left_x <= c.lx; in_ch.left_y <= c.ly; in_ch.left_z <= c.lz;
          in_ch.right_x <= c.rx; in_ch.right_y <= c.ry; in_ch.right_z <= c.rz;
          if (!calm && $urandom_range(0, 9) == 0) gap_tx <= $urandom_range(1, 8);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold, counted on its own
  initial begin
    wait (hold_go);
    hold_rx = 1'b1;
    repeat (400) @(posedge clk);
    hold_rx = 1'b0;
  end

  // monitor and receiver stall
  int gap_rx = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb NOT OK");
      $finish;
    end
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pts.size() == 0) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10) $display("unexpected waypoint %0d %0d %0d",
                                         out_ch.point_x, out_ch.point_y, out_ch.point_z);
        end else begin
          waypoint_t w;
          w = expected_pts.pop_front();
          if (w.x !== out_ch.point_x || w.y !== out_ch.point_y || w.z !== out_ch.point_z ||
              w.last !== out_ch.last || w.ovf !== out_ch.overflow) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10)
              $display("waypoint mismatch exp %0d %0d %0d l%0b o%0b got %0d %0d %0d l%0b o%0b",
                       w.x, w.y, w.z, w.last, w.ovf, out_ch.point_x, out_ch.point_y,
                       out_ch.point_z, out_ch.last, out_ch.overflow);
          end
        end
      end
      if (hold_rx) begin
        out_ch.ready <= 1'b0;
      end else if (gap_rx > 0) begin
        gap_rx <= gap_rx - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) gap_rx <= $urandom_range(1, 8);
      end
    end
  end

  function automatic logic signed [23:0] rnd_coord(int mode);
    case (mode)
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return $signed(24'($urandom_range(0, 16383)) - 24'sd8192);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic add_cmd(logic [1:0] k, int mode);
    path_cmd_t c;
    c.kind = k;
    c.lx = rnd_coord(mode); c.ly = rnd_coord(mode); c.lz = rnd_coord(mode);
    c.rx = rnd_coord(mode); c.ry = rnd_coord(mode); c.rz = rnd_coord(mode);
    pending_cmds = {pending_cmds, c};
  endtask

  // corridor along +z with jitter so that corners appear (mode 3 scatters the portals)
  task automatic add_path(int np, int mode);
    path_cmd_t c;
    int zz;
    add_cmd(KIND_START, mode == 3 ? 3 : 2);
    zz = 0;
    for (int i = 0; i < np; i++) begin
      c.kind = KIND_PORTAL;
      zz += $urandom_range(100, 3000);
      c.lx = $signed(24'($urandom_range(0, 6000)) - 24'sd3000) - 24'sd2000;
      c.rx = c.lx + 24'($urandom_range(0, 4000));
      c.ly = 24'($urandom); c.ry = 24'($urandom_range(0, 50));
      c.lz = zz[23:0];
      c.rz = 24'(zz + $signed(24'($urandom_range(0, 400)) - 24'sd200));
      if (mode == 3) begin c.lx = 24'($urandom); c.rx = 24'($urandom);
        c.lz = 24'($urandom); c.rz = 24'($urandom); end
      pending_cmds = {pending_cmds, c};
    end
    add_cmd(KIND_END, mode == 3 ? 3 : 2);
  endtask

  task automatic drain_and_idle();
    while (pending_cmds.size() > 0 || expected_pts.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_q = v;
  endtask

  initial begin
    int total;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: end without start, extremes, unused kind, empty path, overflow
    add_cmd(KIND_END, 0);
    add_cmd(KIND_START, 0);
    add_cmd(KIND_PORTAL, 1);
    add_cmd(KIND_PORTAL, 0);
    add_cmd(KIND_END, 1);
    add_cmd(KIND_UNUSED, 3);
    add_cmd(KIND_START, 1);
    add_cmd(KIND_END, 0);
    add_path(3, 2);
    drain_and_idle();
    write_limit(16'd0);
    add_path(5, 2);
    add_cmd(KIND_START, 2);
    repeat (DEPTH + 2) add_cmd(KIND_PORTAL, 2);
    add_cmd(KIND_END, 2);
    drain_and_idle();
    write_limit(16'hFFFF);
    total = 0;
    // long receiver hold while sender keeps offering
    hold_go = 1;
    while (total < 360) begin
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) begin add_cmd(2'($urandom_range(0, 3)), 3); total += 1; end
      else if (r == 1) begin add_path($urandom_range(0, 3), 3); total += 5; end
      else begin
        int np;
        np = ($urandom_range(0, 15) == 0) ? $urandom_range(20, DEPTH) : $urandom_range(0, 8);
        add_path(np, 2); total += np + 2;
      end
      if (total > 120 && total < 140) begin
        drain_and_idle();
        write_limit(16'($urandom));
        // send_hold is raised and cleared with no wait between, so the sender does no pause
        send_hold = 1;
        add_path(4, 2);
        send_hold = 0;
        total += 6;
      end
      if (total > 300) calm = 1;
      while (pending_cmds.size() > 40) @(posedge clk);
    end
    drain_and_idle();
    if (!failed) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
